FILE: src/lphm_pkg.sv
`default_nettype none

package lphm_pkg;

  // Default geometry of the slot store
  localparam int DEF_DEPTH     = 1024;
  localparam int DEF_KEY_WIDTH = 64;

  // Fixed field widths of the item and result ports
  localparam int KEY_IN_W = 64;
  localparam int HASH_W   = 32;
  localparam int VAL_W    = 32;
  localparam int USED_W   = 11;
  localparam int CFG_W    = 4;

  // Capacity register: reset value and lowest usable log2
  localparam logic [CFG_W-1:0] CFG_LG_RESET = 4'd10;
  localparam int               LG_MIN       = 1;

  // Load limit: a put is refused once count * LOAD_DEN >= capacity * LOAD_NUM
  localparam int LOAD_NUM = 7;
  localparam int LOAD_DEN = 10;

  // Operation codes
  localparam logic MODE_PUT = 1'b0;
  localparam logic MODE_GET = 1'b1;

  // Outcome of examining one slot
  typedef struct packed {
    logic empty;  // slot unoccupied: walk stops, no match
    logic hit;    // slot holds the same hash and key
    logic last;   // every active slot has now been visited
  } probe_res_t;

endpackage

`default_nettype wire

FILE: src/lphm_ram.sv
`default_nettype none

module lphm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write one word, read one word with registered output
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

FILE: src/lphm_probe.sv
`default_nettype none

module lphm_probe
  import lphm_pkg::*;
#(
  parameter int AW = 10,
  parameter int KW = 64
) (
  input  wire logic [HASH_W+KW+VAL_W:0] slot_word,
  input  wire logic [HASH_W-1:0]        item_hash,
  input  wire logic [KW-1:0]            item_key,
  input  wire logic [AW-1:0]            pos,
  input  wire logic [AW-1:0]            mask,
  input  wire logic [AW:0]              visited,
  input  wire logic [AW:0]              cap,
  output probe_res_t                    res,
  output logic      [AW-1:0]            next_pos,
  output logic      [VAL_W-1:0]         slot_value
);

  localparam int SW = 1 + HASH_W + KW + VAL_W;

  logic              slot_vld;
  logic [HASH_W-1:0] slot_hash;
  logic [KW-1:0]     slot_key;

  // Unpack the stored slot word
  assign slot_vld   = slot_word[SW-1];
  assign slot_hash  = slot_word[SW-2 -: HASH_W];
  assign slot_key   = slot_word[VAL_W +: KW];
  assign slot_value = slot_word[VAL_W-1:0];

  // Classify the slot and step the walk with wraparound
  assign res.empty = !slot_vld;
  assign res.hit   = slot_vld && (slot_hash == item_hash) && (slot_key == item_key);
  assign res.last  = ((visited + (AW+1)'(1)) == cap);
  assign next_pos  = (pos + AW'(1)) & mask;

endmodule

`default_nettype wire

FILE: src/linear_probe_hash_map_unit.sv
// Channel  | Ports                                            | Handshake
// ---------+--------------------------------------------------+------------------------------
// item in  | in_mode, in_key, in_key_hash, in_value           | taken when start && !busy
// result   | out_success, out_value_out, out_entries_used     | out_valid for one cycle
// config   | cfg_wdata                                        | written when cfg_we
//
// A put refused by the load limit leaves the block idle, ready for the next item; any
// other item keeps busy high from accept until the walk ends, after 1 to capacity slots,
// one slot per cycle through the single read port of the slot store.
// After reset and after every cfg_we a clearing pass over all DEPTH slots empties the store;
// busy stays high meanwhile. The result strobe cannot be held off by the receiver.
`default_nettype none

module linear_probe_hash_map_unit
  import lphm_pkg::*;
#(
  parameter int DEPTH     = DEF_DEPTH,
  parameter int KEY_WIDTH = DEF_KEY_WIDTH
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic                in_mode,
  input  wire logic [KEY_IN_W-1:0] in_key,
  input  wire logic [HASH_W-1:0]   in_key_hash,
  input  wire logic [VAL_W-1:0]    in_value,
  output logic                     out_valid,
  output logic                     out_success,
  output logic      [VAL_W-1:0]    out_value_out,
  output logic      [USED_W-1:0]   out_entries_used,
  input  wire logic                cfg_we,
  input  wire logic [CFG_W-1:0]    cfg_wdata
);

  localparam int AW       = $clog2(DEPTH);
  localparam int DEPTH_LG = $clog2(DEPTH + 1) - 1;
  localparam int CW       = $clog2(DEPTH + 1);
  localparam int LW       = CW + 4;
  localparam int LGW      = 5;
  localparam int SW       = 1 + HASH_W + KEY_WIDTH + VAL_W;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PROBE
  } state_t;

  // Clamp a written log2 to the range the store supports
  function automatic logic [LGW-1:0] eff_lg(input logic [CFG_W-1:0] v);
    logic [LGW-1:0] lg;
    lg = LGW'(v);
    if (lg < LGW'(LG_MIN)) lg = LGW'(LG_MIN);
    if (lg > LGW'(DEPTH_LG)) lg = LGW'(DEPTH_LG);
    return lg;
  endfunction

  state_t             state_r, state_nxt;
  logic [AW-1:0]      clr_addr_r, clr_addr_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic [LGW-1:0]     cap_lg_r, cap_lg_nxt;
  logic               mode_r, mode_nxt;
  logic [KEY_WIDTH-1:0] key_r, key_nxt;
  logic [HASH_W-1:0]  hash_r, hash_nxt;
  logic [VAL_W-1:0]   val_r, val_nxt;
  logic [AW-1:0]      pos_r, pos_nxt;
  logic [AW:0]        visited_r, visited_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               out_success_r, out_success_nxt;
  logic [VAL_W-1:0]   out_value_r, out_value_nxt;

  logic [AW-1:0]      mask;
  logic [AW:0]        cap;
  logic               load_ok;
  logic [AW-1:0]      in_pos;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [SW-1:0]      ram_wdata;
  logic               ram_re;
  logic [AW-1:0]      ram_raddr;
  logic [SW-1:0]      ram_rdata;

  probe_res_t         res;
  logic [AW-1:0]      next_pos;
  logic [VAL_W-1:0]   slot_value;

  logic [CW+USED_W-1:0] used_ext;

  // Derive address mask and capacity from the active log2
  always_comb begin
    for (int i = 0; i < AW; i++) begin
      mask[i] = (LGW'(i) < cap_lg_r);
    end
  end

  assign cap     = {1'b0, mask} + (AW+1)'(1);
  assign load_ok = (LW'(count_r) * LW'(LOAD_DEN)) < (LW'(cap) * LW'(LOAD_NUM));
  assign in_pos  = in_key_hash[AW-1:0] & mask;

  lphm_ram #(
    .WIDTH (SW),
    .DEPTH (DEPTH)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  lphm_probe #(
    .AW (AW),
    .KW (KEY_WIDTH)
  ) u_probe (
    .slot_word  (ram_rdata),
    .item_hash  (hash_r),
    .item_key   (key_r),
    .pos        (pos_r),
    .mask       (mask),
    .visited    (visited_r),
    .cap        (cap),
    .res        (res),
    .next_pos   (next_pos),
    .slot_value (slot_value)
  );

  // Sequence clearing, item capture and the slot walk
  always_comb begin
    state_nxt       = state_r;
    clr_addr_nxt    = clr_addr_r;
    count_nxt       = count_r;
    cap_lg_nxt      = cap_lg_r;
    mode_nxt        = mode_r;
    key_nxt         = key_r;
    hash_nxt        = hash_r;
    val_nxt         = val_r;
    pos_nxt         = pos_r;
    visited_nxt     = visited_r;
    out_valid_nxt   = 1'b0;
    out_success_nxt = out_success_r;
    out_value_nxt   = out_value_r;
    ram_we          = 1'b0;
    ram_waddr       = pos_r;
    ram_wdata       = {1'b1, hash_r, key_r, val_r};
    ram_re          = 1'b0;
    ram_raddr       = in_pos;

    unique case (state_r)
      ST_CLEAR: begin
        // Empty one slot per cycle
        ram_we       = 1'b1;
        ram_waddr    = clr_addr_r;
        ram_wdata    = '0;
        clr_addr_nxt = clr_addr_r + AW'(1);
        if (clr_addr_r == AW'(DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          mode_nxt = in_mode;
          key_nxt  = in_key[KEY_WIDTH-1:0];
          hash_nxt = in_key_hash;
          val_nxt  = in_value;
          if (in_mode == MODE_PUT && !load_ok) begin
            // Refuse the put at once
            out_valid_nxt   = 1'b1;
            out_success_nxt = 1'b0;
            out_value_nxt   = '0;
          end else begin
            ram_re      = 1'b1;
            ram_raddr   = in_pos;
            pos_nxt     = in_pos;
            visited_nxt = '0;
            state_nxt   = ST_PROBE;
          end
        end
      end
      ST_PROBE: begin
        if (res.hit || res.empty) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
          if (mode_r == MODE_PUT) begin
            ram_we          = 1'b1;
            out_success_nxt = 1'b1;
            out_value_nxt   = '0;
            if (res.empty) begin
              count_nxt = count_r + CW'(1);
            end
          end else begin
            out_success_nxt = res.hit;
            out_value_nxt   = res.hit ? slot_value : '0;
          end
        end else if (res.last) begin
          // Whole table walked without a stop
          state_nxt       = ST_IDLE;
          out_valid_nxt   = 1'b1;
          out_success_nxt = 1'b0;
          out_value_nxt   = '0;
        end else begin
          // Advance to the next slot
          ram_re      = 1'b1;
          ram_raddr   = next_pos;
          pos_nxt     = next_pos;
          visited_nxt = visited_r + (AW+1)'(1);
        end
      end
      default: begin
        state_nxt    = ST_CLEAR;
        clr_addr_nxt = '0;
      end
    endcase

    // A capacity write restarts the map from empty
    if (cfg_we) begin
      cap_lg_nxt    = eff_lg(cfg_wdata);
      count_nxt     = '0;
      state_nxt     = ST_CLEAR;
      clr_addr_nxt  = '0;
      out_valid_nxt = 1'b0;
    end
  end

  // Hold state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      count_r     <= '0;
      cap_lg_r    <= eff_lg(CFG_LG_RESET);
      out_valid_r <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      clr_addr_r    <= clr_addr_nxt;
      count_r       <= count_nxt;
      cap_lg_r      <= cap_lg_nxt;
      mode_r        <= mode_nxt;
      key_r         <= key_nxt;
      hash_r        <= hash_nxt;
      val_r         <= val_nxt;
      pos_r         <= pos_nxt;
      visited_r     <= visited_nxt;
      out_valid_r   <= out_valid_nxt;
      out_success_r <= out_success_nxt;
      out_value_r   <= out_value_nxt;
    end
  end

  // Drive the ports
  assign used_ext         = {{USED_W{1'b0}}, count_r};
  assign busy             = (state_r != ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_success      = out_success_r;
  assign out_value_out    = out_value_r;
  assign out_entries_used = used_ext[USED_W-1:0];

`ifndef SYNTHESIS
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == ST_IDLE))
    else $error("result strobe while not idle");

  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= cap)
    else $error("entry count above capacity");

  a_get_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PROBE && mode_r == MODE_GET && !cfg_we) |=> (count_r == $past(count_r)))
    else $error("get changed the entry count");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_success_r) |-> (out_value_r == '0))
    else $error("non-zero value on a failed item");
`endif

endmodule

`default_nettype wire

FILE: sim/linear_probe_hash_map_unit_tb.sv
`timescale 1ns / 100ps

module linear_probe_hash_map_unit_tb;
  import lphm_pkg::*;

  localparam int CYCLE_LIMIT = 2_000_000;
  localparam logic [KEY_IN_W-1:0] KEY_MASK = {KEY_IN_W{1'b1}} >> (KEY_IN_W - DEF_KEY_WIDTH);
  localparam int POOL_MAX = 64;

  typedef struct packed {
    logic              success;
    logic [VAL_W-1:0]  value_out;
    logic [USED_W-1:0] entries_used;
  } map_answer_t;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                start;
  logic                busy;
  logic                in_mode;
  logic [KEY_IN_W-1:0] in_key;
  logic [HASH_W-1:0]   in_key_hash;
  logic [VAL_W-1:0]    in_value;
  logic                out_valid;
  logic                out_success;
  logic [VAL_W-1:0]    out_value_out;
  logic [USED_W-1:0]   out_entries_used;
  logic                cfg_we;
  logic [CFG_W-1:0]    cfg_wdata;

  linear_probe_hash_map_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_mode          (in_mode),
    .in_key           (in_key),
    .in_key_hash      (in_key_hash),
    .in_value         (in_value),
    .out_valid        (out_valid),
    .out_success      (out_success),
    .out_value_out    (out_value_out),
    .out_entries_used (out_entries_used),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata)
  );

  // Mirror of the map: capacity register, slots and occupancy
  logic [CFG_W-1:0]    size_lg;
  bit                  slot_full [DEF_DEPTH];
  logic [HASH_W-1:0]   slot_hash_m [DEF_DEPTH];
  logic [KEY_IN_W-1:0] slot_key_m [DEF_DEPTH];
  logic [VAL_W-1:0]    slot_val_m [DEF_DEPTH];
  int unsigned         stored_count;

  map_answer_t answers_due[$];
  int          faults;
  int          cycles;

  // Clock: 2 ns period
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int unsigned table_cap();
    int unsigned lg;
    int unsigned cap;
    lg = 32'(size_lg);
    if (lg < LG_MIN) lg = LG_MIN;
    cap = 1 << lg;
    while (cap > 2 && cap > DEF_DEPTH) cap >>= 1;
    return cap;
  endfunction

  function automatic void wipe_map();
    for (int s = 0; s < DEF_DEPTH; s++) begin
      slot_full[s] = 1'b0;
    end
    stored_count = 0;
  endfunction

  // Apply one put or get to the mirror and return the answer it should give
  function automatic map_answer_t apply_map_op(logic mode, logic [KEY_IN_W-1:0] key_in,
                                               logic [HASH_W-1:0] hash, logic [VAL_W-1:0] val);
    map_answer_t         ans;
    logic [KEY_IN_W-1:0] key;
    int unsigned         cap;
    int unsigned         mask;
    int unsigned         p;
    int unsigned         pos;
    int unsigned         i;
    bit                  stopped;
    bit                  hit;
    key = key_in & KEY_MASK;
    cap = table_cap();
    mask = cap - 1;
    p = hash & mask;
    pos = 0;
    stopped = 1'b0;
    hit = 1'b0;
    // walk from the home slot until an empty slot or a match, wrapping round
    for (i = 0; i < cap && !stopped; i++) begin
      if (!slot_full[p]) begin
        stopped = 1'b1;
        pos = p;
      end else if (slot_hash_m[p] == hash && slot_key_m[p] == key) begin
        stopped = 1'b1;
        hit = 1'b1;
        pos = p;
      end else begin
        p = (p + 1) & mask;
      end
    end
    ans.success = 1'b0;
    ans.value_out = '0;
    if (mode == MODE_PUT) begin
      if (stored_count * LOAD_DEN < cap * LOAD_NUM && stopped) begin
        if (!hit) stored_count++;
        slot_full[pos] = 1'b1;
        slot_hash_m[pos] = hash;
        slot_key_m[pos] = key;
        slot_val_m[pos] = val;
        ans.success = 1'b1;
      end
    end else if (stopped && hit) begin
      ans.success = 1'b1;
      ans.value_out = slot_val_m[pos];
    end
    ans.entries_used = stored_count[USED_W-1:0];
    return ans;
  endfunction

  task automatic note_fault(string msg);
    faults++;
    if (faults <= 10) $display("mismatch: %s", msg);
  endtask

  // Compare each strobed result with the oldest answer due
  always @(posedge clk) begin : check_results
    map_answer_t due;
    if (rst_n && out_valid) begin
      if (answers_due.size() == 0) begin
        note_fault($sformatf("result with none due: success=%0b value_out=%h entries_used=%0d",
                             out_success, out_value_out, out_entries_used));
      end else begin
        due = answers_due.pop_front();
        if (out_success !== due.success)
          note_fault($sformatf("success exp %0b got %0b", due.success, out_success));
        if (out_value_out !== due.value_out)
          note_fault($sformatf("value_out exp %h got %h", due.value_out, out_value_out));
        if (out_entries_used !== due.entries_used)
          note_fault($sformatf("entries_used exp %0d got %0d", due.entries_used,
                               out_entries_used));
      end
    end
  end

  // Cycle counter: end the run if it hangs
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAIL");
    $finish;
  end

  // Present one item and hold it until taken; start is left high
  task automatic send_item(logic mode, logic [KEY_IN_W-1:0] key, logic [HASH_W-1:0] hash,
                           logic [VAL_W-1:0] val);
    start <= 1'b1;
    in_mode <= mode;
    in_key <= key;
    in_key_hash <= hash;
    in_value <= val;
    @(posedge clk);
    while (busy) @(posedge clk);
    answers_due.push_back(apply_map_op(mode, key, hash, val));
  endtask

  task automatic hold_off(int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Stop sending until every answer is in and the block is idle
  task automatic drain_answers();
    start <= 1'b0;
    do @(posedge clk); while (answers_due.size() != 0 || busy);
  endtask

  task automatic write_table_size(logic [CFG_W-1:0] lg);
    drain_answers();
    cfg_we <= 1'b1;
    cfg_wdata <= lg;
    @(posedge clk);
    cfg_we <= 1'b0;
    size_lg = lg;
    wipe_map();
    @(posedge clk);
  endtask

  // Reset capacity: empty lookups, extremes, update, collisions and wrap-round
  task automatic test_reset_table();
    send_item(MODE_GET, 64'h0, 32'h0, 32'h0);
    send_item(MODE_PUT, '1, '1, '1);
    send_item(MODE_GET, '1, '1, 32'h0);
    send_item(MODE_PUT, 64'h0, 32'h0, 32'h0);
    send_item(MODE_GET, 64'h0, 32'h0, 32'hDEAD_BEEF);
    send_item(MODE_PUT, '1, '1, 32'h5A5A_A5A5);
    send_item(MODE_GET, '1, '1, 32'h0);
    // same hash, other key: probe wraps from the top slot
    send_item(MODE_PUT, 64'h1, '1, 32'h1234_5678);
    send_item(MODE_GET, 64'h1, '1, 32'h0);
    // same home slot, other hash: walk the chain and miss
    send_item(MODE_GET, '1, 32'h0000_03FF, 32'h0);
    send_item(MODE_PUT, 64'h2, 32'h8000_0000, 32'hA5A5_5A5A);
    send_item(MODE_GET, 64'h2, 32'h8000_0000, 32'h0);
  endtask

  // Two-slot table: load limit, refused update and a walk over a full table
  task automatic test_tiny_table_limit();
    write_table_size(4'd1);
    send_item(MODE_PUT, 64'hAAAA_0000_0000_0001, 32'h0, 32'h11);
    send_item(MODE_PUT, 64'hBBBB_0000_0000_0002, 32'h1, 32'h22);
    send_item(MODE_PUT, 64'hCCCC_0000_0000_0003, 32'h0, 32'h33);
    send_item(MODE_PUT, 64'hAAAA_0000_0000_0001, 32'h0, 32'h44);
    send_item(MODE_GET, 64'hCCCC_0000_0000_0003, 32'h0, 32'h0);
    send_item(MODE_GET, 64'hBBBB_0000_0000_0002, 32'h1, 32'h0);
  endtask

  // Register values outside the usable range
  task automatic test_capacity_clamp();
    write_table_size(4'd0);
    send_item(MODE_PUT, 64'h10, 32'h5, 32'h1);
    send_item(MODE_PUT, 64'h11, 32'h6, 32'h2);
    send_item(MODE_PUT, 64'h12, 32'h7, 32'h3);
    write_table_size(4'd15);
    send_item(MODE_PUT, 64'hFEED_0000_CAFE_0001, 32'hABCD_E3FF, 32'h7777_0001);
    send_item(MODE_GET, 64'hFEED_0000_CAFE_0001, 32'hABCD_E3FF, 32'h0);
    send_item(MODE_GET, 64'hFEED_0000_CAFE_0001, 32'h0000_03FF, 32'h0);
  endtask

  // Random traffic over a sequence of capacities, mostly on a pool of known keys
  task automatic test_random_tables();
    int                  lg_plan [16] = '{3, 1, 5, 2, 10, 4, 6, 7, 2, 8, 9, 3, 10, 5, 1, 4};
    int                  n_plan [16]  = '{90, 40, 90, 40, 100, 80, 90, 90, 40, 90, 90, 80,
                                          100, 80, 40, 30};
    logic [KEY_IN_W-1:0] pool_key [POOL_MAX];
    logic [HASH_W-1:0]   pool_hash [POOL_MAX];
    logic [KEY_IN_W-1:0] key;
    logic [HASH_W-1:0]   hash;
    logic [6:0]          cluster_mid;
    logic                mode;
    int                  cap;
    int                  pool_n;
    int                  idx;
    int                  r;
    int                  burst_left;
    bit                  steady;
    for (int ph = 0; ph < 16; ph++) begin
      write_table_size(CFG_W'(lg_plan[ph]));
      cap = table_cap();
      pool_n = (cap + 2 < POOL_MAX) ? cap + 2 : POOL_MAX;
      cluster_mid = 7'($urandom);
      steady = ($urandom_range(0, 3) == 0);
      // half the pool crowds into two home slots to build long chains
      for (int k = 0; k < pool_n; k++) begin
        pool_key[k] = {$urandom, $urandom};
        pool_hash[k] = $urandom;
        if ($urandom_range(0, 1)) pool_hash[k][9:0] = {cluster_mid, 3'($urandom_range(0, 1))};
      end
      burst_left = $urandom_range(1, 12);
      for (int k = 0; k < n_plan[ph]; k++) begin
        r = $urandom_range(0, 99);
        idx = $urandom_range(0, pool_n - 1);
        mode = 1'($urandom_range(0, 1));
        key = pool_key[idx];
        hash = pool_hash[idx];
        if (r < 6) begin
          key = {$urandom, $urandom};
          hash = $urandom;
        end else if (r < 11) begin
          hash[$urandom_range(10, 31)] ^= 1'b1;
        end else if (r < 16) begin
          key[$urandom_range(0, 63)] ^= 1'b1;
        end
        send_item(mode, key, hash, $urandom);
        if (k == n_plan[ph] / 2 && (ph == 0 || $urandom_range(0, 2) == 0)) begin
          drain_answers();
        end else if (!steady) begin
          burst_left--;
          if (burst_left == 0) begin
            hold_off(($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8));
            burst_left = $urandom_range(1, 12);
          end
        end
      end
    end
  endtask

  initial begin
    rst_n <= 1'b0;
    start <= 1'b0;
    in_mode <= MODE_PUT;
    in_key <= '0;
    in_key_hash <= '0;
    in_value <= '0;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    faults = 0;
    size_lg = CFG_LG_RESET;
    wipe_map();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_table();
    test_tiny_table_limit();
    test_capacity_clamp();
    test_random_tables();

    drain_answers();
    repeat (16) @(posedge clk);
    if (answers_due.size() != 0) faults++;
    if (faults == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/lphm_pkg.sv
src/lphm_ram.sv
src/lphm_probe.sv
src/linear_probe_hash_map_unit.sv
sim/linear_probe_hash_map_unit_tb.sv
